// File: rtl/core/sync_framed_record_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_FRAMED_RECORD_DEFRAMER_MACROS_SVH
`define SYNC_FRAMED_RECORD_DEFRAMER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SFRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Check that cons holds in the cycle after ante.
`define SFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

// File: rtl/core/sfrd_pkg.sv
`timescale 1ns / 1ps
package sfrd_pkg;

	localparam int MAX_PAYLOAD = 1024;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [7:0] SYNC_FIRST    = 8'h55;
	localparam logic [7:0] SYNC_SECOND   = 8'hAA;
	localparam logic [7:0] MARKER_RESET  = 8'h42;
	localparam logic [6:0] RECSIZE_RESET = 7'd7;
	localparam logic [6:0] RECSIZE_MAX   = 7'd64;
	localparam logic [CNT_W-1:0] STORE_LIMIT = CNT_W'(MAX_PAYLOAD);

	typedef enum logic [3:0] {
		ST_SYNC1   = 4'd0,
		ST_SYNC2   = 4'd1,
		ST_LEN_LO  = 4'd2,
		ST_LEN_HI  = 4'd3,
		ST_MARKER  = 4'd4,
		ST_PAYLOAD = 4'd5,
		ST_CHECK   = 4'd6,
		ST_DONE    = 4'd7,
		ST_ERROR   = 4'd8
	} state_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_MARKER   = 3'd1,
		STAT_CHECKSUM = 3'd2,
		STAT_SIZE     = 3'd3,
		STAT_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ACT_FEED    = 2'd0,
		ACT_RESTART = 2'd1,
		ACT_READ    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MARKER      = 1'b0,
		CFG_RECORD_SIZE = 1'b1
	} cfg_index_t;

endpackage

// File: rtl/core/sfrd_ifs.sv
`timescale 1ns / 1ps
interface sfrd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic [sfrd_pkg::ADDR_W-1:0] read_index;

	modport source (output valid, action, data_byte, read_index, input ready);
	modport sink (input valid, action, data_byte, read_index, output ready);
endinterface

interface sfrd_out_if;
	logic       valid;
	logic       ready;
	logic       frame_done;
	logic [2:0] status;
	logic [sfrd_pkg::CNT_W-1:0] record_count;
	logic [sfrd_pkg::CNT_W-1:0] payload_length;
	logic [7:0] read_data;

	modport source (output valid, frame_done, status, record_count, payload_length, read_data,
		input ready);
	modport sink (input valid, frame_done, status, record_count, payload_length, read_data,
		output ready);
endinterface

// File: rtl/core/sfrd_ram.sv
`timescale 1ns / 1ps
module sfrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/sync_framed_record_deframer.sv
`timescale 1ns / 1ps
// Channel   Role    Carries
// in_ch     sink    action, data_byte, read_index
// out_ch    source  frame_done, status, record_count, payload_length, read_data
// cfg_*     write   marker_value (index 0), record_size (index 1)
//
// One item per cycle unless output stalls; results pass payload RAM read, then output register.
// Parser state in flip-flops; payload bytes go to a 1024 x 8 RAM, at most one write per item.
// arst_n clears parser state, config and valid flags; RAM and data registers are not cleared.
// A stalled output holds its register; input stays ready while the middle stage can move.
`include "sync_framed_record_deframer_macros.svh"

module sync_framed_record_deframer (
	input  logic clk,
	input  logic arst_n,
	sfrd_in_if.sink    in_ch,
	sfrd_out_if.source out_ch,
	input  logic                             cfg_we,
	input  logic [sfrd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = sfrd_pkg::ADDR_W;
	localparam int CW = sfrd_pkg::CNT_W;

	logic [7:0] marker_q;
	logic [6:0] recsize_q;

	sfrd_pkg::state_t  state_q, state_d;
	sfrd_pkg::status_t stat_q, stat_d;
	logic [15:0]   len_q, len_d;
	logic [15:0]   cnt_q, cnt_d, cnt_inc;
	logic [7:0]    sum_q, sum_d;
	logic [CW-1:0] stored_q, stored_d;
	logic [5:0]    bir_q, bir_d;
	logic [6:0]    bir_inc;
	logic [CW-1:0] recs_q, recs_d;
	logic          ovf_q, ovf_d;
	logic          done_d;
	logic [6:0]    eff_size;

	sfrd_pkg::action_t act;
	logic [7:0]    b;
	logic          accept;
	logic          ram_we;
	logic          ram_re;
	logic [7:0]    ram_rdata;

	logic          v_s1, done_s1, rd_ok_s1;
	sfrd_pkg::status_t status_s1;
	logic [CW-1:0] recs_s1, plen_s1;
	logic          s1_adv;

	logic          v_q, out_done_q;
	sfrd_pkg::status_t out_status_q;
	logic [CW-1:0] out_recs_q, out_plen_q;
	logic [7:0]    out_rdata_q;

	assign act    = sfrd_pkg::action_t'(in_ch.action);
	assign b      = in_ch.data_byte;
	assign s1_adv = v_s1 && (!v_q || out_ch.ready);
	assign in_ch.ready = !v_s1 || s1_adv;
	assign accept = in_ch.valid && in_ch.ready;
	assign ram_re = accept && (act == sfrd_pkg::ACT_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q  <= sfrd_pkg::MARKER_RESET;
			recsize_q <= sfrd_pkg::RECSIZE_RESET;
		end else if (cfg_we) begin
			case (sfrd_pkg::cfg_index_t'(cfg_index))
				sfrd_pkg::CFG_MARKER:      marker_q  <= cfg_data;
				sfrd_pkg::CFG_RECORD_SIZE: recsize_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (recsize_q == 7'd0) begin
			eff_size = 7'd1;
		end else if (recsize_q > sfrd_pkg::RECSIZE_MAX) begin
			eff_size = sfrd_pkg::RECSIZE_MAX;
		end else begin
			eff_size = recsize_q;
		end
	end

	always_comb begin
		state_d  = state_q;
		stat_d   = stat_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		sum_d    = sum_q;
		stored_d = stored_q;
		bir_d    = bir_q;
		recs_d   = recs_q;
		ovf_d    = ovf_q;
		done_d   = 1'b0;
		ram_we   = 1'b0;
		bir_inc  = {1'b0, bir_q} + 7'd1;
		cnt_inc  = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
		if (accept) begin
			case (act)
				sfrd_pkg::ACT_FEED: begin
					case (state_q)
						sfrd_pkg::ST_SYNC1: begin
							if (b == sfrd_pkg::SYNC_FIRST) begin
								state_d = sfrd_pkg::ST_SYNC2;
							end
						end
						sfrd_pkg::ST_SYNC2: begin
							if (b == sfrd_pkg::SYNC_SECOND) begin
								state_d = sfrd_pkg::ST_LEN_LO;
							end else if (b != sfrd_pkg::SYNC_FIRST) begin
								state_d = sfrd_pkg::ST_SYNC1;
							end
						end
						sfrd_pkg::ST_LEN_LO: begin
							len_d   = {8'h00, b};
							state_d = sfrd_pkg::ST_LEN_HI;
						end
						sfrd_pkg::ST_LEN_HI: begin
							len_d   = {b, len_q[7:0]};
							state_d = sfrd_pkg::ST_MARKER;
						end
						sfrd_pkg::ST_MARKER: begin
							if (b == marker_q) begin
								stored_d = '0;
								bir_d    = '0;
								recs_d   = '0;
								ovf_d    = 1'b0;
								cnt_d    = 16'd1;
								sum_d    = b;
								state_d  = sfrd_pkg::ST_PAYLOAD;
							end else begin
								stat_d  = sfrd_pkg::STAT_MARKER;
								state_d = sfrd_pkg::ST_ERROR;
								done_d  = 1'b1;
							end
						end
						sfrd_pkg::ST_PAYLOAD: begin
							if (stored_q >= sfrd_pkg::STORE_LIMIT) begin
								ovf_d = 1'b1;
							end else begin
								ram_we   = 1'b1;
								stored_d = stored_q + CW'(1);
								if (bir_inc >= eff_size) begin
									bir_d  = '0;
									recs_d = recs_q + CW'(1);
								end else begin
									bir_d = bir_inc[5:0];
								end
							end
							sum_d = sum_q + b;
							cnt_d = cnt_inc;
							if (cnt_inc >= len_q) begin
								state_d = sfrd_pkg::ST_CHECK;
							end
						end
						sfrd_pkg::ST_CHECK: begin
							done_d = 1'b1;
							if (sum_q != b) begin
								stat_d  = sfrd_pkg::STAT_CHECKSUM;
								state_d = sfrd_pkg::ST_ERROR;
							end else if (ovf_q) begin
								stat_d  = sfrd_pkg::STAT_OVERFLOW;
								state_d = sfrd_pkg::ST_ERROR;
							end else if (bir_q != 6'd0) begin
								stat_d  = sfrd_pkg::STAT_SIZE;
								state_d = sfrd_pkg::ST_ERROR;
							end else begin
								stat_d  = sfrd_pkg::STAT_OK;
								state_d = sfrd_pkg::ST_DONE;
							end
						end
						default: ;
					endcase
				end
				sfrd_pkg::ACT_RESTART: begin
					state_d  = sfrd_pkg::ST_SYNC1;
					stat_d   = sfrd_pkg::STAT_OK;
					len_d    = '0;
					cnt_d    = '0;
					sum_d    = '0;
					stored_d = '0;
					bir_d    = '0;
					recs_d   = '0;
					ovf_d    = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sfrd_pkg::ST_SYNC1;
			stat_q   <= sfrd_pkg::STAT_OK;
			len_q    <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			stored_q <= '0;
			bir_q    <= '0;
			recs_q   <= '0;
			ovf_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			stat_q   <= stat_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			sum_q    <= sum_d;
			stored_q <= stored_d;
			bir_q    <= bir_d;
			recs_q   <= recs_d;
			ovf_q    <= ovf_d;
		end
	end

	sfrd_ram #(
		.WIDTH(8),
		.DEPTH(sfrd_pkg::MAX_PAYLOAD)
	) u_payload_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(stored_q[AW-1:0]),
		.wdata(b),
		.re   (ram_re),
		.raddr(in_ch.read_index),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			done_s1   <= done_d;
			status_s1 <= stat_d;
			recs_s1   <= (state_d == sfrd_pkg::ST_DONE) ? recs_d : '0;
			plen_s1   <= stored_d;
			rd_ok_s1  <= ram_re && ({1'b0, in_ch.read_index} < stored_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (s1_adv) begin
			v_q <= 1'b1;
		end else if (out_ch.ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_done_q   <= done_s1;
			out_status_q <= status_s1;
			out_recs_q   <= recs_s1;
			out_plen_q   <= plen_s1;
			out_rdata_q  <= rd_ok_s1 ? ram_rdata : 8'h00;
		end
	end

	assign out_ch.valid          = v_q;
	assign out_ch.frame_done     = out_done_q;
	assign out_ch.status         = out_status_q;
	assign out_ch.record_count   = out_recs_q;
	assign out_ch.payload_length = out_plen_q;
	assign out_ch.read_data      = out_rdata_q;

	`SFRD_ASSERT_NOW(a_write_in_payload, clk, arst_n, ram_we,
		(state_q == sfrd_pkg::ST_PAYLOAD) && (stored_q < sfrd_pkg::STORE_LIMIT))
	`SFRD_ASSERT_NOW(a_stored_bounded, clk, arst_n, 1'b1,
		(stored_q <= sfrd_pkg::STORE_LIMIT) && ({1'b0, bir_q} < eff_size || ovf_q ||
		state_q != sfrd_pkg::ST_PAYLOAD))
	`SFRD_ASSERT_NEXT(a_ok_lands_done, clk, arst_n,
		accept && done_d && (stat_d == sfrd_pkg::STAT_OK), state_q == sfrd_pkg::ST_DONE)
	`SFRD_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, v_s1 && !s1_adv,
		v_s1 && $stable(plen_s1) && $stable(status_s1))

endmodule

// File: sim/tb_sync_framed_record_deframer.sv
`timescale 1ns / 1ps
module tb_sync_framed_record_deframer;
	import sfrd_pkg::*;

	localparam int ITEMS_TARGET = 1950;
	localparam int WATCHDOG = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic frame_done;
		status_t status;
		logic [CNT_W-1:0] record_count;
		logic [CNT_W-1:0] payload_length;
		logic [7:0] read_data;
	} frame_result_t;

	typedef struct packed {
		action_t act;
		logic [7:0] b;
		logic [ADDR_W-1:0] idx;
		logic fixed;
		frame_result_t res;
	} stim_row_t;

	localparam frame_result_t IDLE_RES = '0;
	localparam frame_result_t MARKER_FAIL = '{1'b1, STAT_MARKER, 11'd0, 11'd0, 8'd0};
	localparam frame_result_t MARKER_HELD = '{1'b0, STAT_MARKER, 11'd0, 11'd0, 8'd0};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_index_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sfrd_in_if in_ch();
	sfrd_out_if out_ch();

	sync_framed_record_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [7:0] mark_reg = MARKER_RESET;
	logic [6:0] rec_size_reg = RECSIZE_RESET;
	state_t pstate;
	logic [15:0] len_declared;
	logic [15:0] tally;
	logic [7:0] csum;
	logic [7:0] store_mem [MAX_PAYLOAD];
	logic [CNT_W-1:0] n_stored;
	int rec_pos;
	logic [CNT_W-1:0] rec_total;
	status_t cur_status;
	bit ovf;

	frame_result_t results_due[$];
	stim_row_t dir_rows[$];
	int errors = 0;
	int items_sent = 0;
	int stall_count = 0;
	int store_high_water = 0;
	bit src_quiet = 1'b0;
	bit snk_quiet = 1'b0;
	bit hold_req = 1'b0;

	function automatic void restart_deframer();
		pstate = ST_SYNC1;
		len_declared = '0;
		tally = '0;
		csum = '0;
		n_stored = '0;
		rec_pos = 0;
		rec_total = '0;
		cur_status = STAT_OK;
		ovf = 1'b0;
	endfunction

	function automatic int record_len();
		if (rec_size_reg == 0) return 1;
		if (rec_size_reg > RECSIZE_MAX) return RECSIZE_MAX;
		return rec_size_reg;
	endfunction

	function automatic frame_result_t deframe_step(action_t act, logic [7:0] b,
			logic [ADDR_W-1:0] idx);
		frame_result_t r;
		r = '0;
		case (act)
			ACT_FEED: begin
				case (pstate)
					ST_SYNC1: if (b == SYNC_FIRST) pstate = ST_SYNC2;
					ST_SYNC2: begin
						if (b == SYNC_SECOND) pstate = ST_LEN_LO;
						else if (b != SYNC_FIRST) pstate = ST_SYNC1;
					end
					ST_LEN_LO: begin
						len_declared = {8'h00, b};
						pstate = ST_LEN_HI;
					end
					ST_LEN_HI: begin
						len_declared[15:8] = b;
						pstate = ST_MARKER;
					end
					ST_MARKER: begin
						if (b == mark_reg) begin
							n_stored = '0;
							rec_pos = 0;
							rec_total = '0;
							ovf = 1'b0;
							tally = 16'd1;
							csum = b;
							pstate = ST_PAYLOAD;
						end else begin
							cur_status = STAT_MARKER;
							pstate = ST_ERROR;
							r.frame_done = 1'b1;
						end
					end
					ST_PAYLOAD: begin
						if (n_stored >= MAX_PAYLOAD) begin
							ovf = 1'b1;
						end else begin
							store_mem[n_stored[ADDR_W-1:0]] = b;
							n_stored = n_stored + 1'b1;
							if (rec_pos + 1 >= record_len()) begin
								rec_pos = 0;
								rec_total = rec_total + 1'b1;
							end else begin
								rec_pos = rec_pos + 1;
							end
						end
						csum = csum + b;
						if (tally != 16'hFFFF) tally = tally + 1'b1;
						if (tally >= len_declared) pstate = ST_CHECK;
					end
					ST_CHECK: begin
						r.frame_done = 1'b1;
						pstate = ST_ERROR;
						if (csum != b) cur_status = STAT_CHECKSUM;
						else if (ovf) cur_status = STAT_OVERFLOW;
						else if (rec_pos != 0) cur_status = STAT_SIZE;
						else begin
							cur_status = STAT_OK;
							pstate = ST_DONE;
						end
					end
					default: ;
				endcase
			end
			ACT_RESTART: restart_deframer();
			ACT_READ: if (idx < n_stored) r.read_data = store_mem[idx];
			default: ;
		endcase
		r.status = cur_status;
		r.record_count = (pstate == ST_DONE) ? rec_total : '0;
		r.payload_length = n_stored;
		return r;
	endfunction

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_gap();
		if (src_quiet || $urandom_range(0, 99) < 60) return 0;
		return stall_len();
	endfunction

	function automatic stim_row_t row(action_t act, logic [7:0] b,
			logic [ADDR_W-1:0] idx = '0, logic fixed = 1'b0,
			frame_result_t res = '0);
		stim_row_t s;
		s.act = act;
		s.b = b;
		s.idx = idx;
		s.fixed = fixed;
		s.res = res;
		return s;
	endfunction

	function automatic void add_row(stim_row_t s);
		dir_rows.insert(dir_rows.size(), s);
	endfunction

	task automatic send_item(input action_t act, input logic [7:0] b,
			input logic [ADDR_W-1:0] idx, input logic fixed = 1'b0,
			input frame_result_t fixed_res = '0);
		int gap;
		bit ignored;
		frame_result_t res;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.data_byte <= b;
		in_ch.read_index <= idx;
		do @(posedge clk); while (!in_ch.ready);
		ignored = (act == ACT_NONE) ||
			(act == ACT_FEED && (pstate == ST_DONE || pstate == ST_ERROR));
		res = deframe_step(act, b, idx);
		if (!ignored) items_sent++;
		if (n_stored > store_high_water) store_high_water = n_stored;
		results_due.insert(results_due.size(), fixed ? fixed_res : res);
	endtask

	task automatic write_reg(input cfg_index_t which, input logic [7:0] val);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (which == CFG_MARKER) mark_reg = val;
		else rec_size_reg = val[6:0];
	endtask

	task automatic send_frame(input int force_len);
		int r, plen, eff, nreads;
		bit abort;
		logic [15:0] dlen;
		logic [7:0] mk, sum, b;
		logic [ADDR_W-1:0] idx;
		eff = record_len();
		abort = 1'b0;
		if (force_len == 0 && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				b = $urandom;
				if (b == SYNC_FIRST) b = 8'h00;
				send_item(ACT_FEED, b, '0);
			end
		end
		send_item(ACT_FEED, SYNC_FIRST, '0);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_item(ACT_FEED, SYNC_FIRST, '0);
		send_item(ACT_FEED, SYNC_SECOND, '0);

		r = $urandom_range(0, 99);
		if (force_len > 0) begin
			plen = force_len;
			dlen = plen + 1;
		end else if (r < 55) begin
			plen = eff * $urandom_range(1, 3);
			dlen = plen + 1;
		end else if (r < 82) begin
			plen = $urandom_range(1, 2 * eff + 3);
			dlen = plen + 1;
		end else if (r < 92) begin
			plen = 1;
			dlen = $urandom_range(0, 2);
		end else begin
			abort = 1'b1;
			plen = $urandom_range(3, 20);
			dlen = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(1100, 65534));
		end
		send_item(ACT_FEED, dlen[7:0], '0);
		send_item(ACT_FEED, dlen[15:8], '0);

		mk = mark_reg;
		if (force_len == 0 && $urandom_range(0, 11) == 0) mk = mark_reg + 8'($urandom_range(1, 255));
		send_item(ACT_FEED, mk, '0);
		if (mk == mark_reg) begin
			sum = mk;
			for (int i = 0; i < plen; i++) begin
				if ($urandom_range(0, 99) < 3) send_item(ACT_NONE, $urandom, $urandom);
				b = $urandom;
				sum = sum + b;
				send_item(ACT_FEED, b, '0);
			end
			if (abort) begin
				send_item(ACT_RESTART, $urandom, $urandom);
				return;
			end
			if (force_len == 0 && $urandom_range(0, 9) == 0) sum = sum ^ 8'($urandom_range(1, 255));
			send_item(ACT_FEED, sum, '0);
		end

		repeat ($urandom_range(0, 2)) send_item(ACT_FEED, $urandom, '0);
		if (n_stored != 0) send_item(ACT_READ, $urandom, n_stored - 1'b1);
		nreads = $urandom_range(0, 4);
		repeat (nreads) begin
			if (n_stored != 0 && $urandom_range(0, 3) != 0) begin
				idx = $urandom_range(0, n_stored - 1);
				send_item(ACT_READ, $urandom, idx);
			end else if (store_high_water > n_stored) begin
				idx = $urandom_range(n_stored, store_high_water - 1);
				send_item(ACT_READ, $urandom, idx);
			end
		end
		send_item(ACT_RESTART, $urandom, $urandom);
	endtask

	task automatic check_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		frame_result_t e;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				stall_count <= 0;
			end else begin
				stall_count <= stall_count + 1;
				if (stall_count >= WATCHDOG) begin
					$display("%0t: no progress", $time);
					$display("Some tests failed");
					$finish;
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result with nothing expected, status %0d", $time,
						out_ch.status);
					errors++;
				end else begin
					e = results_due.pop_front();
					check_field("frame_done", e.frame_done, out_ch.frame_done);
					check_field("status", e.status, out_ch.status);
					check_field("record_count", e.record_count, out_ch.record_count);
					check_field("payload_length", e.payload_length, out_ch.payload_length);
					check_field("read_data", e.read_data, out_ch.read_data);
				end
			end
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (snk_quiet || $urandom_range(0, 99) < 65) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b0;
				repeat (stall_len() - 1) @(negedge clk);
			end
		end
	end

	initial begin
		int phase;
		logic [7:0] m;
		logic [7:0] s;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MARKER;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_FEED;
		in_ch.data_byte = '0;
		in_ch.read_index = '0;
		restart_deframer();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_row(row(ACT_RESTART, 8'h00, '0, 1'b1, IDLE_RES));
		add_row(row(ACT_NONE, 8'hFF, 10'h3FF, 1'b1, IDLE_RES));
		add_row(row(ACT_FEED, SYNC_FIRST));
		add_row(row(ACT_FEED, 8'h12));
		add_row(row(ACT_FEED, SYNC_FIRST));
		add_row(row(ACT_FEED, SYNC_FIRST));
		add_row(row(ACT_FEED, SYNC_SECOND));
		add_row(row(ACT_FEED, 8'h00));
		add_row(row(ACT_FEED, 8'h00));
		add_row(row(ACT_FEED, 8'h00, '0, 1'b1, MARKER_FAIL));
		add_row(row(ACT_FEED, SYNC_FIRST, '0, 1'b1, MARKER_HELD));
		add_row(row(ACT_RESTART, 8'h00, '0, 1'b1, IDLE_RES));
		add_row(row(ACT_FEED, SYNC_FIRST));
		add_row(row(ACT_FEED, SYNC_SECOND));
		add_row(row(ACT_FEED, 8'h08));
		add_row(row(ACT_FEED, 8'h00));
		add_row(row(ACT_FEED, MARKER_RESET));
		add_row(row(ACT_FEED, 8'hFF));
		add_row(row(ACT_FEED, 8'h00));
		add_row(row(ACT_FEED, 8'h01));
		add_row(row(ACT_FEED, 8'h80));
		add_row(row(ACT_FEED, 8'h7F));
		add_row(row(ACT_FEED, 8'h10));
		add_row(row(ACT_FEED, 8'h20));
		add_row(row(ACT_FEED, 8'h71));
		add_row(row(ACT_READ, 8'h00, 10'd6));
		add_row(row(ACT_READ, 8'h00, 10'd0));
		add_row(row(ACT_RESTART, 8'h00, '0, 1'b1, IDLE_RES));
		foreach (dir_rows[i])
			send_item(dir_rows[i].act, dir_rows[i].b, dir_rows[i].idx, dir_rows[i].fixed,
				dir_rows[i].res);

		phase = 0;
		while (items_sent < ITEMS_TARGET || phase < 5) begin
			case (phase)
				0: begin m = 8'h00; s = 8'd1; end
				1: begin m = 8'hFF; s = 8'd64; end
				2: begin m = SYNC_FIRST; s = 8'd0; end
				3: begin m = SYNC_SECOND; s = 8'd127; end
				4: begin m = 8'h80; s = 8'd65; end
				default: begin
					m = $urandom;
					s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: $urandom_range(1, 12);
				end
			endcase
			write_reg(CFG_MARKER, m);
			write_reg(CFG_RECORD_SIZE, s);
			src_quiet = (phase % 3 == 2);
			snk_quiet = (phase % 4 == 3);
			if (phase == 1) begin
				src_quiet = 1'b1;
				hold_req = 1'b1;
				send_frame(MAX_PAYLOAD + 1);
				src_quiet = 1'b0;
			end
			repeat ((phase < 5) ? $urandom_range(1, 2) : $urandom_range(4, 8)) send_frame(0);
			phase++;
		end

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/sfrd_pkg.sv
rtl/core/sfrd_ifs.sv
rtl/core/sfrd_ram.sv
rtl/core/sync_framed_record_deframer.sv
sim/tb_sync_framed_record_deframer.sv
